[hw/rtl/segregated_free_list_allocator_macros.svh]
// Assertion macros shared by the checker of the small-block allocator.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SFLA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[hw/rtl/sfla_pkg.sv]
// Types, constants and helpers of the small-block allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int ALIGN_BYTES     = 8;
    localparam int ALIGN_SH        = 3;
    localparam int MAX_SMALL_BYTES = 128;
    localparam int NUM_LISTS       = 16;
    localparam int LIST_W          = 4;
    localparam int ARENA_BYTES     = 65536;
    localparam int ADDR_W          = 17;
    localparam int LINK_DEPTH      = ARENA_BYTES / ALIGN_BYTES;
    localparam int LINK_AW         = 13;
    localparam int SZ_W            = 8;
    localparam int CNT_W           = 6;
    localparam int MAX_REFILL      = 32;

    localparam logic [ADDR_W-1:0] EMPTY_MARK = 17'h1FFFF;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REALLOC = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERSIZE = 2'd1;
    localparam logic [1:0] STAT_NOMEM    = 2'd2;

    localparam logic [CNT_W-1:0] REFILL_RESET = 6'd20;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] size;
        logic [15:0] old_size;
        logic [15:0] addr;
    } t_sfla_in;

    typedef struct packed {
        logic [15:0] block_addr;
        logic [1:0]  status;
    } t_sfla_out;

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_ALLOC, S_POP, S_CARVE, S_DIV, S_SCAN, S_SCAV, S_THREAD, S_LINK
    } t_sfla_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_PUSH_FREE, OP_POP_RD, OP_POP_WR, OP_REFILL_INIT, OP_TAKE_ALL,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_TAKE, OP_SPILL_GROW, OP_SPILL_FAIL, OP_SCAN_NEXT,
        OP_SCAV_RD, OP_SCAV_WR, OP_NOMEM_CLR, OP_THREAD_HEAD, OP_THREAD_LINK
    } t_dp_op;

    typedef enum logic [1:0] {HS_ALLOC, HS_FREE, HS_LEFT, HS_SCAN} t_head_sel;

    typedef enum logic [1:0] {RES_ZERO, RES_ADDR, RES_CHUNK} t_res_src;

    typedef struct packed {
        t_dp_op     op;
        t_head_sel  hsel;
        logic       emit;
        t_res_src   src;
        logic [1:0] status;
    } t_sfla_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       free_ok;
        logic       alloc_ok;
        logic       head_empty;
        logic       fit_all;
        logic       fit_one;
        logic       arena_ok;
        logic       div_more;
        logic       scan_last;
        logic       cnt_gt1;
        logic       thread_last;
    } t_sfla_stat;

    typedef struct packed {
        logic              over;
        logic [LIST_W-1:0] k;
    } t_cls;

    // size class of a byte count; zero counts as one granule
    function automatic t_cls class_of(input logic [ADDR_W-1:0] n);
        t_cls              c;
        logic [ADDR_W-1:0] m;
        logic [ADDR_W-1:0] g;
        m      = (n == '0) ? ADDR_W'(1) : n;
        g      = (m - ADDR_W'(1)) >> ALIGN_SH;
        c.over = (m > ADDR_W'(MAX_SMALL_BYTES));
        c.k    = g[LIST_W-1:0];
        return c;
    endfunction

endpackage

[hw/rtl/sfla_ctrl.sv]
// Controller state machine of the small-block allocator.
// Depends on sfla_pkg; drives sfla_datapath through command and status structs.
`timescale 1ns / 1ps

module sfla_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sfla_pkg::t_sfla_stat i_stat,
    output sfla_pkg::t_sfla_cmd  o_cmd
);
    import sfla_pkg::*;

    t_sfla_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_FREE;
            end
            S_FREE: begin
                if (i_stat.func == FUNC_ALLOC || i_stat.func == FUNC_REALLOC) n_state = S_ALLOC;
                else n_state = S_IDLE;
            end
            S_ALLOC: begin
                if (!i_stat.alloc_ok) n_state = S_IDLE;
                else if (!i_stat.head_empty) n_state = S_POP;
                else n_state = S_CARVE;
            end
            S_POP: n_state = S_IDLE;
            S_CARVE: begin
                if (i_stat.fit_all) n_state = S_THREAD;
                else if (i_stat.fit_one) n_state = S_DIV;
                else if (i_stat.arena_ok) n_state = S_CARVE;
                else n_state = S_SCAN;
            end
            S_DIV: begin
                if (!i_stat.div_more) n_state = S_THREAD;
            end
            S_SCAN: begin
                if (!i_stat.head_empty) n_state = S_SCAV;
                else if (i_stat.scan_last) n_state = S_IDLE;
            end
            S_SCAV: n_state = S_CARVE;
            S_THREAD: begin
                if (i_stat.cnt_gt1) n_state = S_LINK;
                else n_state = S_IDLE;
            end
            S_LINK: begin
                if (i_stat.thread_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NOP;
        o_cmd.hsel   = HS_ALLOC;
        o_cmd.src    = RES_ZERO;
        o_cmd.status = STAT_OK;
        busy         = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) o_cmd.op = OP_LOAD;
            end
            S_FREE: begin
                o_cmd.hsel = HS_FREE;
                if ((i_stat.func == FUNC_FREE || i_stat.func == FUNC_REALLOC) && i_stat.free_ok) begin
                    o_cmd.op = OP_PUSH_FREE;
                end
                if (i_stat.func == FUNC_FREE) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.src    = RES_ADDR;
                    o_cmd.status = i_stat.free_ok ? STAT_OK : STAT_OVERSIZE;
                end else if (i_stat.func != FUNC_ALLOC && i_stat.func != FUNC_REALLOC) begin
                    o_cmd.emit = 1'b1;
                end
            end
            S_ALLOC: begin
                if (!i_stat.alloc_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = STAT_OVERSIZE;
                end else if (!i_stat.head_empty) begin
                    o_cmd.op = OP_POP_RD;
                end else begin
                    o_cmd.op = OP_REFILL_INIT;
                end
            end
            S_POP: begin
                o_cmd.op   = OP_POP_WR;
                o_cmd.emit = 1'b1;
                o_cmd.src  = RES_CHUNK;
            end
            S_CARVE: begin
                o_cmd.hsel = HS_LEFT;
                if (i_stat.fit_all) o_cmd.op = OP_TAKE_ALL;
                else if (i_stat.fit_one) o_cmd.op = OP_DIV_INIT;
                else if (i_stat.arena_ok) o_cmd.op = OP_SPILL_GROW;
                else o_cmd.op = OP_SPILL_FAIL;
            end
            S_DIV: begin
                o_cmd.op = i_stat.div_more ? OP_DIV_STEP : OP_DIV_TAKE;
            end
            S_SCAN: begin
                o_cmd.hsel = HS_SCAN;
                if (!i_stat.head_empty) begin
                    o_cmd.op = OP_SCAV_RD;
                end else if (i_stat.scan_last) begin
                    o_cmd.op     = OP_NOMEM_CLR;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = STAT_NOMEM;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                end
            end
            S_SCAV: begin
                o_cmd.hsel = HS_SCAN;
                o_cmd.op   = OP_SCAV_WR;
            end
            S_THREAD: begin
                if (i_stat.cnt_gt1) begin
                    o_cmd.op = OP_THREAD_HEAD;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = RES_CHUNK;
                end
            end
            S_LINK: begin
                o_cmd.op = OP_THREAD_LINK;
                if (i_stat.thread_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = RES_CHUNK;
                end
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

[hw/rtl/sfla_datapath.sv]
// Datapath of the small-block allocator: list heads, link store, pool and arena.
// Depends on sfla_pkg; sequenced by sfla_ctrl.
`timescale 1ns / 1ps

module sfla_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfla_pkg::t_sfla_in    i_cmd,
    input  logic                  i_cfg_wr_en,
    input  logic [5:0]            i_cfg_wr_data,
    input  sfla_pkg::t_sfla_cmd   i_ctl,
    output sfla_pkg::t_sfla_stat  o_stat,
    output logic                  o_result_strobe,
    output sfla_pkg::t_sfla_out   o_result
);
    import sfla_pkg::*;

    logic [CNT_W-1:0]  r_bpr;
    logic [1:0]        r_func;
    logic [15:0]       r_size, r_old_size, r_addr;
    logic [ADDR_W-1:0] r_head [NUM_LISTS];
    logic [ADDR_W-1:0] r_link [LINK_DEPTH];
    logic [ADDR_W-1:0] r_rd_data;
    logic              r_rd_oob;
    logic [ADDR_W-1:0] r_pool_start, r_pool_end, r_arena_top, r_heap_total;
    logic [SZ_W-1:0]   r_sz;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_chunk, r_here, r_rem, r_acc;
    logic [LIST_W-1:0] r_scan;
    logic              r_done;
    t_sfla_out         r_out;

    t_cls              acls, fcls, lcls;
    logic [LIST_W-1:0] hidx;
    logic [ADDR_W-1:0] head_rd, left, total, rnd, want, room, sz17, scav_sz, link_val;
    logic [ADDR_W-1:0] wr_addr, wr_data;
    logic              wr_en, left_nz;
    logic              head_we;
    logic [LIST_W-1:0] head_widx;
    logic [ADDR_W-1:0] head_wdata;
    logic [CNT_W-1:0]  cnt_init;

    always_comb begin
        acls     = class_of({1'b0, r_size});
        fcls     = class_of({1'b0, (r_func == FUNC_FREE) ? r_size : r_old_size});
        left     = (r_pool_end >= r_pool_start) ? r_pool_end - r_pool_start : '0;
        left_nz  = (left != '0);
        lcls     = class_of(left);
        sz17     = ADDR_W'(r_sz);
        total    = sz17 * ADDR_W'(r_cnt);
        rnd      = ((r_heap_total >> 4) + ADDR_W'(ALIGN_BYTES - 1)) & ~ADDR_W'(ALIGN_BYTES - 1);
        want     = (total << 1) + rnd;
        room     = ADDR_W'(ARENA_BYTES) - r_arena_top;
        scav_sz  = ADDR_W'({1'b0, r_scan} + 5'd1) << ALIGN_SH;
        link_val = (r_cnt == CNT_W'(1)) ? EMPTY_MARK : r_here + sz17;
        if (r_bpr == '0) cnt_init = CNT_W'(1);
        else if (r_bpr > CNT_W'(MAX_REFILL)) cnt_init = CNT_W'(MAX_REFILL);
        else cnt_init = r_bpr;
        case (i_ctl.hsel)
            HS_ALLOC: hidx = acls.k;
            HS_FREE:  hidx = fcls.k;
            HS_LEFT:  hidx = lcls.k;
            HS_SCAN:  hidx = r_scan;
            default:  hidx = acls.k;
        endcase
        head_rd = r_head[hidx];
    end

    always_comb begin
        o_stat             = '0;
        o_stat.func        = r_func;
        o_stat.free_ok     = !fcls.over;
        o_stat.alloc_ok    = !acls.over;
        o_stat.head_empty  = (head_rd == EMPTY_MARK);
        o_stat.fit_all     = (left >= total);
        o_stat.fit_one     = (left >= sz17);
        o_stat.arena_ok    = (want <= room);
        o_stat.div_more    = (r_rem >= sz17);
        o_stat.scan_last   = (r_scan == LIST_W'(NUM_LISTS - 1));
        o_stat.cnt_gt1     = (r_cnt > CNT_W'(1));
        o_stat.thread_last = (r_cnt == CNT_W'(1));
    end

    // link store write port and list head write port
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_here;
        wr_data    = head_rd;
        head_we    = 1'b0;
        head_widx  = hidx;
        head_wdata = head_rd;
        case (i_ctl.op)
            OP_PUSH_FREE: begin
                wr_en      = 1'b1;
                wr_addr    = {1'b0, r_addr};
                head_we    = 1'b1;
                head_wdata = {1'b0, r_addr};
            end
            OP_SPILL_GROW, OP_SPILL_FAIL: begin
                wr_en      = left_nz;
                wr_addr    = r_pool_start;
                head_we    = left_nz;
                head_wdata = r_pool_start;
            end
            OP_POP_WR: begin
                head_we    = 1'b1;
                head_widx  = acls.k;
                head_wdata = r_rd_oob ? EMPTY_MARK : r_rd_data;
            end
            OP_SCAV_WR: begin
                head_we    = 1'b1;
                head_widx  = r_scan;
                head_wdata = r_rd_oob ? EMPTY_MARK : r_rd_data;
            end
            OP_THREAD_HEAD: begin
                head_we    = 1'b1;
                head_widx  = acls.k;
                head_wdata = r_chunk + sz17;
            end
            OP_THREAD_LINK: begin
                wr_en   = 1'b1;
                wr_data = link_val;
            end
            default: wr_en = 1'b0;
        endcase
        // drop writes beyond the link store
        if (wr_addr[ADDR_W-1]) wr_en = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_link[wr_addr[ADDR_W-2:ALIGN_SH]] <= wr_data;
        r_rd_data <= r_link[head_rd[ADDR_W-2:ALIGN_SH]];
        r_rd_oob  <= head_rd[ADDR_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpr        <= REFILL_RESET;
            r_pool_start <= '0;
            r_pool_end   <= '0;
            r_arena_top  <= '0;
            r_heap_total <= '0;
            r_done       <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) r_head[i] <= EMPTY_MARK;
        end else begin
            if (i_cfg_wr_en) r_bpr <= i_cfg_wr_data;
            if (head_we) r_head[head_widx] <= head_wdata;
            r_done <= i_ctl.emit;
            case (i_ctl.op)
                OP_TAKE_ALL:   r_pool_start <= r_pool_start + total;
                OP_DIV_TAKE:   r_pool_start <= r_pool_start + r_acc;
                OP_SPILL_GROW: begin
                    r_pool_start <= r_arena_top;
                    r_pool_end   <= r_arena_top + want;
                    r_arena_top  <= r_arena_top + want;
                    r_heap_total <= r_heap_total + want;
                end
                OP_SCAV_WR: begin
                    r_pool_start <= r_here;
                    r_pool_end   <= r_here + scav_sz;
                end
                OP_NOMEM_CLR: begin
                    r_pool_start <= '0;
                    r_pool_end   <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            case (i_ctl.src)
                RES_ADDR:  r_out.block_addr <= r_addr;
                RES_CHUNK: r_out.block_addr <= r_chunk[15:0];
                default:   r_out.block_addr <= '0;
            endcase
            r_out.status <= i_ctl.status;
        end
        case (i_ctl.op)
            OP_LOAD: begin
                r_func     <= i_cmd.func;
                r_size     <= i_cmd.size;
                r_old_size <= i_cmd.old_size;
                r_addr     <= i_cmd.addr;
            end
            OP_POP_RD: r_chunk <= head_rd;
            OP_REFILL_INIT: begin
                r_sz  <= SZ_W'({1'b0, acls.k} + 5'd1) << ALIGN_SH;
                r_cnt <= cnt_init;
            end
            OP_TAKE_ALL: r_chunk <= r_pool_start;
            OP_DIV_INIT: begin
                r_rem <= left;
                r_cnt <= '0;
                r_acc <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= r_rem - sz17;
                r_cnt <= r_cnt + CNT_W'(1);
                r_acc <= r_acc + sz17;
            end
            OP_DIV_TAKE:    r_chunk <= r_pool_start;
            OP_SPILL_FAIL:  r_scan <= acls.k;
            OP_SCAN_NEXT:   r_scan <= r_scan + LIST_W'(1);
            OP_SCAV_RD:     r_here <= head_rd;
            OP_THREAD_HEAD: begin
                r_here <= r_chunk + sz17;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            OP_THREAD_LINK: begin
                r_here <= r_here + sz17;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            default: r_rem <= r_rem;
        endcase
    end

    assign o_result_strobe = r_done;
    assign o_result        = r_out;

endmodule

[hw/rtl/segregated_free_list_allocator.sv]
// Top level of the small-block allocator: controller plus datapath.
// Depends on sfla_pkg, sfla_ctrl and sfla_datapath.
`timescale 1ns / 1ps
//
// Usage: drive i_cmd and raise start; the beat is taken at an edge where busy
// is low. One result beat per command appears on o_result for exactly one
// cycle with o_result_strobe high; the receiver cannot stall it.
// Path per command: a free or a reserved code answers from the free step, an
// oversize allocate from the allocate step, and an allocate served from a list
// after one pop. A refill that fits the pool threads the refill count of blocks
// (one link write per cycle through the single link-store write port); each
// arena growth returns to the carve step; a partial pool split adds one subtract
// per block plus a take step; scavenging walks one list per cycle, up to 16,
// then takes the block. Out of memory answers once the scan reaches the last
// list and finds it empty; a split covers at most 31 blocks.
// busy is low again while the result beat is on the ports, so a new command
// may be taken in that cycle.
// i_cfg_wr_en writes blocks_per_refill; write it only while idle.
// Reset: all lists empty, pool and arena empty, blocks_per_refill 20.
// The link store is not cleared; only written entries are ever read.

module segregated_free_list_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sfla_pkg::t_sfla_in  i_cmd,
    input  logic                i_cfg_wr_en,
    input  logic [5:0]          i_cfg_wr_data,
    output logic                o_result_strobe,
    output sfla_pkg::t_sfla_out o_result
);
    import sfla_pkg::*;

    t_sfla_cmd  ctl;
    t_sfla_stat stat;

    sfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (ctl)
    );

    sfla_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

[hw/rtl/sfla_checker.sv]
// Port-level checker for the small-block allocator, bound to the top level.
// Depends on sfla_pkg and segregated_free_list_allocator_macros.svh.
`timescale 1ns / 1ps
`include "segregated_free_list_allocator_macros.svh"

module sfla_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_strobe,
    input sfla_pkg::t_sfla_out o_result
);
    import sfla_pkg::*;

    `SFLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SFLA_ASSERT_IMPL(a_status_code, o_result_strobe, o_result.status <= STAT_NOMEM)
    `SFLA_ASSERT_IMPL(a_strobe_after_busy, o_result_strobe, $past(busy))
    `SFLA_ASSERT_NEXT(a_single_beat, o_result_strobe, !o_result_strobe)

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (.*);
